// ----- rtl/bci_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the CIoU pipeline.
// No dependencies.
`default_nettype none
package bci_pkg;

    localparam int CRD_W   = 36;     // CORDIC x/y datapath
    localparam int ANG_W   = 32;     // angle, Q2.30
    localparam int DIV_W   = 40;     // dividend/divisor width
    localparam int Q_W     = 16;     // quotient bits
    localparam int RAT_W   = 17;     // Q.16 ratio incl. 1.0
    localparam int V_W     = 18;
    localparam int TAB_LEN = 24;
    localparam logic [30:0] FOUR_OVER_PI2_Q32 = 31'd1740684681;
    localparam logic [RAT_W-1:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [14:0]        aw;
        logic [14:0]        ah;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [14:0]        bw;
        logic [14:0]        bh;
    } box_t;

    typedef struct packed {
        logic zero;
        logic sat;
    } div_flags_t;

    typedef struct packed {
        logic [V_W-1:0]   v;
        logic [DIV_W-1:0] iou_n;
        logic [DIV_W-1:0] iou_d;
        div_flags_t       iou_f;
        logic [DIV_W-1:0] dt_n;
        logic [DIV_W-1:0] dt_d;
        div_flags_t       dt_f;
    } front_t;

    function automatic logic [ANG_W-1:0] atan_tab(input int unsigned i);
        logic [ANG_W-1:0] t;
        case (i)
            0:       t = 32'h3243F6A8;
            1:       t = 32'h1DAC6705;
            2:       t = 32'h0FADBAFC;
            3:       t = 32'h07F56EA6;
            4:       t = 32'h03FEAB76;
            5:       t = 32'h01FFD55B;
            6:       t = 32'h00FFFAAA;
            7:       t = 32'h007FFF55;
            8:       t = 32'h003FFFEA;
            9:       t = 32'h001FFFFD;
            10:      t = 32'h000FFFFF;
            11:      t = 32'h0007FFFF;
            12:      t = 32'h0003FFFF;
            13:      t = 32'h0001FFFF;
            14:      t = 32'h0000FFFF;
            15:      t = 32'h00007FFF;
            16:      t = 32'h00003FFF;
            17:      t = 32'h00001FFF;
            18:      t = 32'h00000FFF;
            19:      t = 32'h000007FF;
            20:      t = 32'h000003FF;
            21:      t = 32'h000001FF;
            22:      t = 32'h000000FF;
            23:      t = 32'h0000007F;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bci_cordic_cell.sv -----
// One vectoring CORDIC step (atan2), registered.
// Depends on bci_pkg.
`default_nettype none
module bci_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [bci_pkg::CRD_W-1:0]      x_in,
    input  wire logic signed [bci_pkg::CRD_W-1:0]      y_in,
    input  wire logic signed [bci_pkg::ANG_W-1:0]      z_in,
    output logic signed [bci_pkg::CRD_W-1:0]           x_out,
    output logic signed [bci_pkg::CRD_W-1:0]           y_out,
    output logic signed [bci_pkg::ANG_W-1:0]           z_out
);
    logic signed [bci_pkg::CRD_W-1:0] x_next, y_next;
    logic signed [bci_pkg::ANG_W-1:0] z_next, ang;

    always_comb
    begin
        ang    = signed'(bci_pkg::atan_tab(STEP));
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        if (y_in > 0)
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ang;
        end
        else if (y_in < 0)
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out <= x_next;
            y_out <= y_next;
            z_out <= z_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bci_div_cell.sv -----
// One restoring-division step: one quotient bit per cell, registered.
// Depends on bci_pkg.
`default_nettype none
module bci_div_cell (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [bci_pkg::DIV_W-1:0]     r_in,
    input  wire logic [bci_pkg::DIV_W-1:0]     d_in,
    input  wire logic [bci_pkg::Q_W-1:0]       q_in,
    output logic [bci_pkg::DIV_W-1:0]          r_out,
    output logic [bci_pkg::DIV_W-1:0]          d_out,
    output logic [bci_pkg::Q_W-1:0]            q_out
);
    logic [bci_pkg::DIV_W:0] r2, diff;

    assign r2   = {r_in, 1'b0};
    assign diff = r2 - {1'b0, d_in};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_out <= d_in;
            if (r2 >= {1'b0, d_in})
            begin
                r_out <= diff[bci_pkg::DIV_W-1:0];
                q_out <= {q_in[bci_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                r_out <= r2[bci_pkg::DIV_W-1:0];
                q_out <= {q_in[bci_pkg::Q_W-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bci_front.sv -----
// Four-stage front end: box geometry, products, sums, aspect term v, divider setup.
// Depends on bci_pkg.
`default_nettype none
module bci_front (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire bci_pkg::box_t                     box,
    input  wire logic [7:0]                        eps,
    input  wire logic signed [bci_pkg::ANG_W-1:0]  za,
    input  wire logic signed [bci_pkg::ANG_W-1:0]  zb,
    output bci_pkg::front_t                        fo
);
    logic signed [18:0] al, ar, at, ab, bl, br, bt, bb;
    logic signed [19:0] ix_s, iy_s, cw_s, ch_s, dx_s, dy_s;
    logic signed [32:0] dz_s;

    logic [18:0] ix_reg, iy_reg, cw_reg, ch_reg;
    logic [16:0] dx_reg, dy_reg;
    logic [14:0] aw_reg, ah_reg, bw_reg, bh_reg;
    logic [31:0] dz_reg;

    logic [37:0] inter_reg, cw2_reg, ch2_reg;
    logic [29:0] aa_reg, ba_reg;
    logic [33:0] dx2_reg, dy2_reg;
    logic [63:0] dd_reg;

    logic [bci_pkg::DIV_W-1:0] uni_reg, c2_reg, rho2_reg, inter3_reg;
    logic [64:0]               vprod;
    logic [bci_pkg::V_W-1:0]   v_reg;

    always_comb
    begin
        al = (19'(box.ax) <<< 1) - 19'(box.aw);
        ar = (19'(box.ax) <<< 1) + 19'(box.aw);
        at = (19'(box.ay) <<< 1) - 19'(box.ah);
        ab = (19'(box.ay) <<< 1) + 19'(box.ah);
        bl = (19'(box.bx) <<< 1) - 19'(box.bw);
        br = (19'(box.bx) <<< 1) + 19'(box.bw);
        bt = (19'(box.by) <<< 1) - 19'(box.bh);
        bb = (19'(box.by) <<< 1) + 19'(box.bh);
        ix_s = 20'((ar < br) ? ar : br) - 20'((al > bl) ? al : bl);
        iy_s = 20'((ab < bb) ? ab : bb) - 20'((at > bt) ? at : bt);
        cw_s = 20'((ar > br) ? ar : br) - 20'((al < bl) ? al : bl);
        ch_s = 20'((ab > bb) ? ab : bb) - 20'((at < bt) ? at : bt);
        dx_s = (20'(box.bx) - 20'(box.ax)) <<< 1;
        dy_s = (20'(box.by) - 20'(box.ay)) <<< 1;
        dz_s = 33'(zb) - 33'(za);
        vprod = 65'(dd_reg[63:30]) * 65'(bci_pkg::FOUR_OVER_PI2_Q32);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // geometry
            ix_reg <= (ix_s < 0) ? '0 : ix_s[18:0];
            iy_reg <= (iy_s < 0) ? '0 : iy_s[18:0];
            cw_reg <= cw_s[18:0];
            ch_reg <= ch_s[18:0];
            dx_reg <= (dx_s < 0) ? 17'(-dx_s) : dx_s[16:0];
            dy_reg <= (dy_s < 0) ? 17'(-dy_s) : dy_s[16:0];
            dz_reg <= (dz_s < 0) ? 32'(-dz_s) : dz_s[31:0];
            aw_reg <= box.aw;
            ah_reg <= box.ah;
            bw_reg <= box.bw;
            bh_reg <= box.bh;
            // products
            inter_reg <= 38'(ix_reg) * 38'(iy_reg);
            cw2_reg   <= 38'(cw_reg) * 38'(cw_reg);
            ch2_reg   <= 38'(ch_reg) * 38'(ch_reg);
            aa_reg    <= 30'(aw_reg) * 30'(ah_reg);
            ba_reg    <= 30'(bw_reg) * 30'(bh_reg);
            dx2_reg   <= 34'(dx_reg) * 34'(dx_reg);
            dy2_reg   <= 34'(dy_reg) * 34'(dy_reg);
            dd_reg    <= 64'(dz_reg) * 64'(dz_reg);
            // sums
            uni_reg    <= (40'(aa_reg) << 2) + (40'(ba_reg) << 2) - 40'(inter_reg)
                          + 40'(eps);
            c2_reg     <= 40'(cw2_reg) + 40'(ch2_reg) + 40'(eps);
            rho2_reg   <= 40'(dx2_reg) + 40'(dy2_reg);
            inter3_reg <= 40'(inter_reg);
            v_reg      <= vprod[63:46];
            // divider setup
            fo.v        <= v_reg;
            fo.iou_n    <= inter3_reg;
            fo.iou_d    <= uni_reg;
            fo.iou_f    <= '{zero: (uni_reg == '0), sat: (inter3_reg >= uni_reg)};
            fo.dt_n     <= rho2_reg;
            fo.dt_d     <= c2_reg;
            fo.dt_f     <= '{zero: (c2_reg == '0), sat: (rho2_reg >= c2_reg)};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bbox_complete_iou.sv -----
// Complete IoU of two boxes (Q8.8 in, Q2.14 out); pipeline of CORDIC and divider cells.
// One word per cycle while the pipeline advances, set by the fully pipelined cell rows.
// The whole pipeline advances while the output register is empty or being taken.
// Reset (rst_n low, async) clears all valid bits and sets eps_reg to 1.
// Depends on bci_pkg, bci_front, bci_cordic_cell, bci_div_cell.
`default_nettype none
module bbox_complete_iou #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // a_center_x[15:0] a_center_y[31:16] a_width[46:32] a_height[61:47]
    // b_center_x[77:62] b_center_y[93:78] b_width[108:94] b_height[123:109]
    input  wire logic [127:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // ciou[15:0]
    output logic [15:0]        m_tdata,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_data
);
    localparam int N   = CORDIC_STEPS;
    localparam int LAT = N + 41;
    localparam int QW  = bci_pkg::Q_W;
    localparam int DW  = bci_pkg::DIV_W;

    logic           en;
    logic [7:0]     eps_reg;
    logic [LAT-1:0] vld_reg;

    bci_pkg::box_t box_p [0:N];
    logic signed [bci_pkg::CRD_W-1:0] xa [0:N];
    logic signed [bci_pkg::CRD_W-1:0] ya [0:N];
    logic signed [bci_pkg::ANG_W-1:0] za [0:N];
    logic signed [bci_pkg::CRD_W-1:0] xb [0:N];
    logic signed [bci_pkg::CRD_W-1:0] yb [0:N];
    logic signed [bci_pkg::ANG_W-1:0] zb [0:N];

    bci_pkg::front_t fo;

    logic [DW-1:0] ir [0:QW];
    logic [DW-1:0] id [0:QW];
    logic [QW-1:0] iq [0:QW];
    logic [DW-1:0] dr [0:QW];
    logic [DW-1:0] dd [0:QW];
    logic [QW-1:0] dq [0:QW];
    logic [bci_pkg::V_W-1:0] v1 [0:QW];
    bci_pkg::div_flags_t     if1 [0:QW];
    bci_pkg::div_flags_t     df1 [0:QW];

    logic [bci_pkg::RAT_W-1:0] iou_reg, dt_reg;
    logic [bci_pkg::V_W-1:0]   v2_reg;
    logic [DW-1:0]             den;

    logic [DW-1:0] ar_ [0:QW];
    logic [DW-1:0] ad_ [0:QW];
    logic [QW-1:0] aq_ [0:QW];
    logic [bci_pkg::RAT_W-1:0] iou_p [0:QW];
    logic [bci_pkg::RAT_W-1:0] dt_p  [0:QW];
    logic [bci_pkg::V_W-1:0]   v_p   [0:QW];
    bci_pkg::div_flags_t       af    [0:QW];

    logic [bci_pkg::RAT_W-1:0] alpha;
    logic [34:0]               va_prod;
    logic [bci_pkg::RAT_W-1:0] iou_h_reg, dt_h_reg;
    logic [18:0]               va_reg;
    logic signed [19:0]        res;
    logic signed [17:0]        res_sh;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= 8'd1;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                eps_reg <= cfg_data;
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // input register and CORDIC seeds
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            box_p[0] <= '{ax: s_tdata[15:0],    ay: s_tdata[31:16],
                          aw: s_tdata[46:32],   ah: s_tdata[61:47],
                          bx: s_tdata[77:62],   by: s_tdata[93:78],
                          bw: s_tdata[108:94],  bh: s_tdata[123:109]};
            ya[0] <= bci_pkg::CRD_W'({s_tdata[46:32], 16'b0});
            xa[0] <= bci_pkg::CRD_W'({16'(s_tdata[61:47]) + 16'(eps_reg), 16'b0});
            za[0] <= '0;
            yb[0] <= bci_pkg::CRD_W'({s_tdata[108:94], 16'b0});
            xb[0] <= bci_pkg::CRD_W'({16'(s_tdata[123:109]) + 16'(eps_reg), 16'b0});
            zb[0] <= '0;
        end
    end

    generate
        for (genvar k = 0; k < N; k++)
        begin : g_cordic
            always_ff @(posedge clk)
            begin
                if (en)
                    box_p[k+1] <= box_p[k];
            end
            bci_cordic_cell #(.STEP(k)) u_ca (
                .clk(clk), .en(en),
                .x_in(xa[k]), .y_in(ya[k]), .z_in(za[k]),
                .x_out(xa[k+1]), .y_out(ya[k+1]), .z_out(za[k+1])
            );
            bci_cordic_cell #(.STEP(k)) u_cb (
                .clk(clk), .en(en),
                .x_in(xb[k]), .y_in(yb[k]), .z_in(zb[k]),
                .x_out(xb[k+1]), .y_out(yb[k+1]), .z_out(zb[k+1])
            );
        end
    endgenerate

    bci_front u_front (
        .clk(clk), .en(en), .box(box_p[N]), .eps(eps_reg),
        .za(za[N]), .zb(zb[N]), .fo(fo)
    );

    assign ir[0]  = fo.iou_n;
    assign id[0]  = fo.iou_d;
    assign iq[0]  = '0;
    assign dr[0]  = fo.dt_n;
    assign dd[0]  = fo.dt_d;
    assign dq[0]  = '0;
    assign v1[0]  = fo.v;
    assign if1[0] = fo.iou_f;
    assign df1[0] = fo.dt_f;

    generate
        for (genvar k = 0; k < QW; k++)
        begin : g_div1
            bci_div_cell u_di (
                .clk(clk), .en(en), .r_in(ir[k]), .d_in(id[k]), .q_in(iq[k]),
                .r_out(ir[k+1]), .d_out(id[k+1]), .q_out(iq[k+1])
            );
            bci_div_cell u_dd (
                .clk(clk), .en(en), .r_in(dr[k]), .d_in(dd[k]), .q_in(dq[k]),
                .r_out(dr[k+1]), .d_out(dd[k+1]), .q_out(dq[k+1])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v1[k+1]  <= v1[k];
                    if1[k+1] <= if1[k];
                    df1[k+1] <= df1[k];
                end
            end
        end
    endgenerate

    // quotient fix-up, then alpha setup
    assign den = DW'(v2_reg) + DW'(bci_pkg::ONE_Q16) - DW'(iou_reg) + DW'(eps_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iou_reg <= if1[QW].zero ? '0 : (if1[QW].sat ? bci_pkg::ONE_Q16
                                                         : bci_pkg::RAT_W'(iq[QW]));
            dt_reg  <= df1[QW].zero ? '0 : (df1[QW].sat ? bci_pkg::ONE_Q16
                                                         : bci_pkg::RAT_W'(dq[QW]));
            v2_reg  <= v1[QW];
            ar_[0]   <= DW'(v2_reg);
            ad_[0]   <= den;
            iou_p[0] <= iou_reg;
            dt_p[0]  <= dt_reg;
            v_p[0]   <= v2_reg;
            af[0]    <= '{zero: (den == '0), sat: (DW'(v2_reg) >= den)};
        end
    end

    assign aq_[0] = '0;

    generate
        for (genvar k = 0; k < QW; k++)
        begin : g_div2
            bci_div_cell u_da (
                .clk(clk), .en(en), .r_in(ar_[k]), .d_in(ad_[k]), .q_in(aq_[k]),
                .r_out(ar_[k+1]), .d_out(ad_[k+1]), .q_out(aq_[k+1])
            );
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    iou_p[k+1] <= iou_p[k];
                    dt_p[k+1]  <= dt_p[k];
                    v_p[k+1]   <= v_p[k];
                    af[k+1]    <= af[k];
                end
            end
        end
    endgenerate

    assign alpha   = af[QW].zero ? '0 : (af[QW].sat ? bci_pkg::ONE_Q16
                                                    : bci_pkg::RAT_W'(aq_[QW]));
    assign va_prod = 35'(v_p[QW]) * 35'(alpha);
    assign res     = 20'(iou_h_reg) - 20'(dt_h_reg) - 20'(va_reg);
    assign res_sh  = 18'(res >>> 2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va_reg    <= va_prod[34:16];
            iou_h_reg <= iou_p[QW];
            dt_h_reg  <= dt_p[QW];
            m_tdata   <= (res_sh > 18'sd16383) ? 16'd16383 :
                         ((res_sh < -18'sd32768) ? 16'h8000 : res_sh[15:0]);
        end
    end
endmodule
`default_nettype wire

// ----- bench/tb_bbox_complete_iou.sv -----
// Testbench for bbox_complete_iou: streams box pairs, predicts complete IoU per pair
// in fixed point and checks each result word in order. Depends on bci_pkg and the RTL.
`timescale 1ns / 1ps
module tb_bbox_complete_iou;

    localparam int LATENCY = 16 + 41;
    localparam int WATCHDOG_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;

    logic [15:0] ciou_expected[$];
    int unsigned eps_value;
    int          fail_count;
    int          results_seen;
    int          idle_cycles;
    bit          stall_enable;

    bbox_complete_iou uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint ratio_q16(longint n, longint d);
        longint q;
        longint r;
        q = 0;
        r = n;
        if (d == 0)
            return 0;
        if (n >= d)
            return 65536;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint angle_q30(longint y, longint x);
        longint z;
        longint nx;
        longint ny;
        z = 0;
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < 16; i++)
        begin
            if (y == 0)
                break;
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + longint'(bci_pkg::atan_tab(i));
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - longint'(bci_pkg::atan_tab(i));
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic logic [15:0] ciou_of(bci_pkg::box_t b, longint eps);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint al, ar, at, ab, bl, br, bt, bb;
        longint ix, iy, inter, uni, iou, cw, ch, c2, dx, dy, rho2, dterm;
        longint diff, sq, v, den, alpha, va, res;
        logic [127:0] prod;
        ax = b.ax; ay = b.ay; aw = b.aw; ah = b.ah;
        bx = b.bx; by = b.by; bw = b.bw; bh = b.bh;
        al = 2*ax - aw; ar = 2*ax + aw; at = 2*ay - ah; ab = 2*ay + ah;
        bl = 2*bx - bw; br = 2*bx + bw; bt = 2*by - bh; bb = 2*by + bh;
        ix = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
        iy = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
        if (ix < 0) ix = 0;
        if (iy < 0) iy = 0;
        inter = ix * iy;
        uni = 4*aw*ah + 4*bw*bh - inter + eps;
        iou = ratio_q16(inter, uni);
        cw = ((ar > br) ? ar : br) - ((al < bl) ? al : bl);
        ch = ((ab > bb) ? ab : bb) - ((at < bt) ? at : bt);
        c2 = cw*cw + ch*ch + eps;
        dx = 2*bx - 2*ax;
        dy = 2*by - 2*ay;
        rho2 = dx*dx + dy*dy;
        dterm = ratio_q16(rho2, c2);
        diff = angle_q30(bw, bh + eps) - angle_q30(aw, ah + eps);
        if (diff < 0) diff = -diff;
        prod = 128'(diff) * 128'(diff);
        sq = longint'(prod >> 30);
        prod = 128'(sq) * 128'(bci_pkg::FOUR_OVER_PI2_Q32);
        v = longint'(prod >> 46);
        den = v + 65536 - iou + eps;
        alpha = ratio_q16(v, den);
        va = (v * alpha) >>> 16;
        res = (iou - dterm - va) >>> 2;
        if (res > 16383) res = 16383;
        if (res < -32768) res = -32768;
        return res[15:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            n = 0;
        if (n != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_box(bci_pkg::box_t b);
        if (stall_enable)
            random_gap();
        s_tdata <= {4'b0, b.bh, b.bw, b.by, b.bx, b.ah, b.aw, b.ay, b.ax};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ciou_expected = {ciou_expected, ciou_of(b, eps_value)};
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (ciou_expected.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_eps(int unsigned value);
        drain();
        cfg_data <= value[7:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        eps_value = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic bci_pkg::box_t random_box();
        bci_pkg::box_t b;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        b.ax = 16'($urandom); b.ay = 16'($urandom);
        b.bx = 16'($urandom); b.by = 16'($urandom);
        b.aw = 15'($urandom); b.ah = 15'($urandom);
        b.bw = 15'($urandom); b.bh = 15'($urandom);
        if (mode < 6)
        begin
            // nearby boxes of moderate size, mostly overlapping
            b.ax = 16'($signed($urandom_range(0, 8000)) - 4000);
            b.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
            b.aw = 15'($urandom_range(0, 6000));
            b.ah = 15'($urandom_range(0, 6000));
            b.bx = b.ax + 16'($signed($urandom_range(0, 2000)) - 1000);
            b.by = b.ay + 16'($signed($urandom_range(0, 2000)) - 1000);
            b.bw = b.aw + 15'($urandom_range(0, 1000));
            b.bh = b.ah + 15'($urandom_range(0, 1000));
        end
        else if (mode == 6)
            b.bh = b.ah;
        else if (mode == 7)
        begin
            b.bx = b.ax; b.by = b.ay; b.bw = b.aw; b.bh = b.ah;
        end
        return b;
    endfunction

    task automatic test_directed();
        bci_pkg::box_t b;
        b = '0;
        send_box(b);
        b = '{16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff};
        send_box(b);
        b = '{16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff};
        send_box(b);
        b = '{16'sh0100, 16'sh0100, 15'h0200, 15'h0200, 16'sh0100, 16'sh0100, 15'h0200, 15'h0200};
        send_box(b);
        b = '{16'sh0000, 16'sh0000, 15'h7fff, 15'h0001, 16'sh0000, 16'sh0000, 15'h0001, 15'h7fff};
        send_box(b);
        b = '{16'sh0000, 16'sh0000, 15'h0000, 15'h0000, 16'sh0400, 16'shfc00, 15'h0100, 15'h0000};
        send_box(b);
        b = '{16'sh7fff, 16'sh8000, 15'h0001, 15'h0001, 16'sh8000, 16'sh7fff, 15'h0001, 15'h0001};
        send_box(b);
        b = '{16'sh0010, 16'shfff0, 15'h0300, 15'h0100, 16'sh0020, 16'shffe0, 15'h0200, 15'h0280};
        send_box(b);
    endtask

    task automatic test_eps_settings();
        bci_pkg::box_t b;
        write_eps(0);
        b = '0;
        send_box(b);
        b = '{16'sh0100, 16'sh0100, 15'h0200, 15'h0200, 16'sh0100, 16'sh0100, 15'h0200, 15'h0200};
        send_box(b);
        b = '{16'sh0000, 16'sh0000, 15'h0000, 15'h0000, 16'sh0400, 16'sh0000, 15'h0100, 15'h0000};
        send_box(b);
        write_eps(255);
        send_box(b);
        b = '{16'sh0000, 16'sh0000, 15'h0003, 15'h0002, 16'sh0001, 16'sh0000, 15'h0002, 15'h0001};
        send_box(b);
        write_eps(1);
    endtask

    task automatic test_random();
        int unsigned eps_list[4] = '{1, 0, 255, 17};
        for (int phase = 0; phase < 4; phase++)
        begin
            write_eps(eps_list[phase]);
            stall_enable = (phase != 1);
            for (int i = 0; i < 250; i++)
                send_box(random_box());
        end
        stall_enable = 1'b1;
    endtask

    always @(negedge clk)
        m_tready <= stall_enable ? ($urandom_range(0, 19) == 0 ? 1'b0 :
                                    $urandom_range(0, 3) != 0) : 1'b1;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (ciou_expected.size() == 0)
                report_mismatch($sformatf("unexpected ciou word %h", m_tdata));
            else if (m_tdata !== ciou_expected[0])
                report_mismatch($sformatf("ciou got %h want %h", m_tdata, ciou_expected[0]));
            if (ciou_expected.size() != 0)
                void'(ciou_expected.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || (!s_tvalid && ciou_expected.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_data = '0;
        eps_value = 1;
        fail_count = 0;
        results_seen = 0;
        idle_cycles = 0;
        stall_enable = 1;
        repeat (2) @(negedge clk);
        rst_n = 1;
        test_directed();
        test_eps_settings();
        test_random();
        drain();
        $display("covered directed extremes, eps 0/1/17/255, %0d result words checked",
                 results_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/bci_pkg.sv
rtl/bci_cordic_cell.sv
rtl/bci_div_cell.sv
rtl/bci_front.sv
rtl/bbox_complete_iou.sv
bench/tb_bbox_complete_iou.sv
